/* src/azrot_pkg.sv */
// Shared widths, outcome codes and flag bundle for the rotation matrix block.
// Depends on nothing; every module of the block but azrot_isqrt imports it.
package azrot_pkg;

  localparam int MAG_W  = 30;           // normalized magnitude, below 2^30
  localparam int SQ_W   = 2 * MAG_W;    // square of one magnitude
  localparam int SUM_W  = SQ_W + 2;     // sum of three squares
  localparam int ROOT_W = 31;           // square roots and quotients
  localparam int Q_W    = 31;           // Q1.30 quotient magnitude
  localparam int FRAC_W = 30;           // fraction bits of Q1.30
  localparam int DIV_W  = 62;           // divider remainder width
  localparam int OUT_W  = 32;           // matrix entry width
  localparam int THR_W  = 16;           // threshold register width

  localparam logic [1:0] OUTCOME_ROTATED = 2'd0;
  localparam logic [1:0] OUTCOME_ALIGNED = 2'd1;
  localparam logic [1:0] OUTCOME_ZERO    = 2'd2;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;   // sign of x, y, z at bit 0, 1, 2
  } front_flags_t;

endpackage

/* src/azrot_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with side tag.
// Depends on nothing but its parameters.
module azrot_isqrt #(
  parameter int RAD_W = 62,
  parameter int TAG_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [RAD_W-1:0]            rad_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [(RAD_W+1)/2-1:0]      root_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int RW = (RAD_W + 1) / 2;
  localparam int IW = 2 * RW + 1;

  logic          v_q    [RW];
  logic [IW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [TAG_W-1:0] tag_q [RW];

  genvar j;
  for (j = 0; j < RW; j++) begin : g_stage
    logic          v_in;
    logic [IW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [TAG_W-1:0] tag_in;
    logic [IW-1:0] inc;
    logic          hit;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = IW'(rad_i);
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign tag_in  = tag_q[j-1];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign inc = (IW'(root_in) << (RW - j)) + (IW'(1) << (2 * (RW - 1 - j)));
    assign hit = rem_in >= inc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= hit ? rem_in - inc : rem_in;
      root_q[j] <= hit ? (root_in | (RW'(1) << (RW - 1 - j))) : root_in;
      tag_q[j]  <= tag_in;
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

/* src/azrot_div.sv */
// Pipelined rounded Q1.30 divider: round(num * 2^30 / den), one bit per stage.
// Depends on azrot_pkg for widths.
module azrot_div
  import azrot_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [Q_W-1:0]   num_i,
  input  logic [ROOT_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic [TAG_W-1:0] tag_o
);

  logic              v0_q;
  logic [DIV_W-1:0]  rem0_q;
  logic [ROOT_W-1:0] den0_q;
  logic [TAG_W-1:0]  tag0_q;

  // form the rounded numerator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem0_q <= (DIV_W'(num_i) << FRAC_W) + DIV_W'(den_i >> 1);
    den0_q <= den_i;
    tag0_q <= tag_i;
  end

  logic              v_q    [Q_W];
  logic [DIV_W-1:0]  rem_q  [Q_W];
  logic [ROOT_W-1:0] den_q  [Q_W];
  logic [Q_W-1:0]    quot_q [Q_W];
  logic [TAG_W-1:0]  tag_q  [Q_W];

  genvar j;
  for (j = 0; j < Q_W; j++) begin : g_stage
    logic              v_in;
    logic [DIV_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [Q_W-1:0]    quot_in;
    logic [TAG_W-1:0]  tag_in;
    logic [DIV_W-1:0]  den_sh;
    logic              hit;

    if (j == 0) begin : g_first
      assign v_in    = v0_q;
      assign rem_in  = rem0_q;
      assign den_in  = den0_q;
      assign quot_in = '0;
      assign tag_in  = tag0_q;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
      assign tag_in  = tag_q[j-1];
    end

    assign den_sh = DIV_W'(den_in) << (Q_W - 1 - j);
    assign hit    = rem_in >= den_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= hit ? rem_in - den_sh : rem_in;
      quot_q[j] <= hit ? (quot_in | (Q_W'(1) << (Q_W - 1 - j))) : quot_in;
      den_q[j]  <= den_in;
      tag_q[j]  <= tag_in;
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

/* src/azrot_front.sv */
// Front end: input register, magnitudes, common normalizing shift, squares.
// Depends on azrot_pkg.
module azrot_front
  import azrot_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [COORD_WIDTH-1:0] disp_x_i,
  input  logic [COORD_WIDTH-1:0] disp_y_i,
  input  logic [COORD_WIDTH-1:0] disp_z_i,
  output logic                   valid_o,
  output front_flags_t           flags_o,
  output logic [MAG_W-1:0]       mag_x_o,
  output logic [MAG_W-1:0]       mag_y_o,
  output logic [MAG_W-1:0]       mag_z_o,
  output logic [SUM_W-1:0]       sum_xy_o,
  output logic [SUM_W-1:0]       sum_all_o
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = $clog2(W);
  localparam int EW = W + MAG_W - 1;

  // stage A: raw input
  logic vA_q;
  logic [W-1:0] dA_q [3];
  // stage B: magnitudes and maximum
  logic vB_q;
  logic [2:0] negB_q, negB_d;
  logic [W-1:0] magB_q [3];
  logic [W-1:0] magB_d [3];
  logic [W-1:0] mB_q, mB_d;
  // stage C: leading one position
  logic vC_q;
  front_flags_t flC_q;
  logic [W-1:0] magC_q [3];
  logic [PW-1:0] posC_q, posC_d;
  // stage D: normalized magnitudes
  logic vD_q;
  front_flags_t flD_q;
  logic [MAG_W-1:0] magD_q [3];
  // stage E: squares
  logic vE_q;
  front_flags_t flE_q;
  logic [MAG_W-1:0] magE_q [3];
  logic [SQ_W-1:0] sqE_q [3];
  // stage F: sums
  logic vF_q;
  front_flags_t flF_q;
  logic [MAG_W-1:0] magF_q [3];
  logic [SUM_W-1:0] sxyF_q, sallF_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
      vC_q <= 1'b0;
      vD_q <= 1'b0;
      vE_q <= 1'b0;
      vF_q <= 1'b0;
    end else begin
      vA_q <= valid_i;
      vB_q <= vA_q;
      vC_q <= vB_q;
      vD_q <= vC_q;
      vE_q <= vD_q;
      vF_q <= vE_q;
    end
  end

  always_comb begin
    mB_d = '0;
    for (int i = 0; i < 3; i++) begin
      negB_d[i] = dA_q[i][W-1];
      magB_d[i] = negB_d[i] ? (~dA_q[i] + W'(1)) : dA_q[i];
      if (magB_d[i] > mB_d) mB_d = magB_d[i];
    end
  end

  always_comb begin
    posC_d = '0;
    for (int i = 0; i < W; i++) begin
      if (mB_q[i]) posC_d = PW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    dA_q[0] <= disp_x_i;
    dA_q[1] <= disp_y_i;
    dA_q[2] <= disp_z_i;

    negB_q <= negB_d;
    mB_q   <= mB_d;

    flC_q.neg  <= negB_q;
    flC_q.zero <= (mB_q == '0);
    posC_q     <= posC_d;

    flD_q <= flC_q;
    flE_q <= flD_q;
    flF_q <= flE_q;

    sxyF_q  <= SUM_W'(sqE_q[0]) + SUM_W'(sqE_q[1]);
    sallF_q <= SUM_W'(sqE_q[0]) + SUM_W'(sqE_q[1]) + SUM_W'(sqE_q[2]);

    for (int i = 0; i < 3; i++) begin
      magB_q[i] <= magB_d[i];
      magC_q[i] <= magB_q[i];
      // largest lands in [2^29, 2^30); right shifts truncate
      magD_q[i] <= MAG_W'((EW'(magC_q[i]) << (MAG_W - 1)) >> posC_q);
      magE_q[i] <= magD_q[i];
      sqE_q[i]  <= SQ_W'(magD_q[i]) * SQ_W'(magD_q[i]);
      magF_q[i] <= magE_q[i];
    end
  end

  assign valid_o   = vF_q;
  assign flags_o   = flF_q;
  assign mag_x_o   = magF_q[0];
  assign mag_y_o   = magF_q[1];
  assign mag_z_o   = magF_q[2];
  assign sum_xy_o  = sxyF_q;
  assign sum_all_o = sallF_q;

endmodule

/* src/azrot_back.sv */
// Back end: outcome, sine root, Rodrigues products, saturation, output register.
// Depends on azrot_pkg and azrot_isqrt.
module azrot_back
  import azrot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [THR_W-1:0]      thr_i,
  input  logic [Q_W-1:0]        q_norm_i,
  input  logic [Q_W-1:0]        q_c_i,
  input  logic [Q_W-1:0]        q_n0_i,
  input  logic [Q_W-1:0]        q_n1_i,
  input  logic                  zero_i,
  input  logic                  r_zero_i,
  input  logic [2:0]            neg_i,
  output logic                  done_o,
  output logic [OUT_W-1:0]      rot_o [9],
  output logic [1:0]            outcome_o
);

  localparam int RAD_W = SQ_W + 1;
  localparam int PR_W  = 2 * Q_W;
  localparam int KM_W  = Q_W + 32;
  localparam int SV_W  = 34;
  localparam int AD_W  = 35;
  localparam logic signed [AD_W-1:0] ONE_Q30 = AD_W'(1) <<< FRAC_W;

  typedef struct packed {
    logic [1:0]        outcome;
    logic signed [32:0] c;
    logic [31:0]       omc;
    logic [Q_W-1:0]    p00;
    logic [Q_W-1:0]    p01;
    logic [Q_W-1:0]    p11;
    logic              p01_neg;
    logic [Q_W-1:0]    n0m;
    logic [Q_W-1:0]    n1m;
    logic              n0_neg;
    logic              n1_neg;
  } stag_t;

  function automatic logic [33:0] rnd30(input logic [63:0] x);
    rnd30 = 34'((x + (64'd1 << (FRAC_W - 1))) >> FRAC_W);
  endfunction

  function automatic logic signed [SV_W-1:0] signed_of(input logic [33:0] m, input logic neg);
    signed_of = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic signed [AD_W-1:0] v);
    if (v > ONE_Q30) begin
      sat = OUT_W'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      sat = OUT_W'(-ONE_Q30);
    end else begin
      sat = OUT_W'(v);
    end
  endfunction

  // G1: outcome, square of c, squares and cross product of the axis components
  logic vG1_q;
  logic [1:0] outG1_q;
  logic [Q_W-1:0] cmG1_q, n0G1_q, n1G1_q;
  logic cnegG1_q, n0negG1_q, n1negG1_q;
  logic [PR_W-1:0] csqG1_q, p00G1_q, p01G1_q, p11G1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vG1_q <= 1'b0;
    end else begin
      vG1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_i) begin
      outG1_q <= OUTCOME_ZERO;
    end else if (q_norm_i < Q_W'(thr_i) || r_zero_i) begin
      outG1_q <= OUTCOME_ALIGNED;
    end else begin
      outG1_q <= OUTCOME_ROTATED;
    end
    cmG1_q    <= q_c_i;
    cnegG1_q  <= !neg_i[2];
    n0G1_q    <= q_n0_i;
    n1G1_q    <= q_n1_i;
    n0negG1_q <= neg_i[1];
    n1negG1_q <= !neg_i[0];
    csqG1_q   <= PR_W'(q_c_i) * PR_W'(q_c_i);
    p00G1_q   <= PR_W'(q_n0_i) * PR_W'(q_n0_i);
    p01G1_q   <= PR_W'(q_n0_i) * PR_W'(q_n1_i);
    p11G1_q   <= PR_W'(q_n1_i) * PR_W'(q_n1_i);
  end

  // G2: radicand for the sine, rounded products, 1 - c
  logic vG2_q;
  logic [RAD_W-1:0] radG2_q;
  stag_t tagG2_q;
  logic signed [32:0] c_s;

  assign c_s = 33'(signed_of(34'(cmG1_q), cnegG1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vG2_q <= 1'b0;
    end else begin
      vG2_q <= vG1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    radG2_q         <= (RAD_W'(1) << (2 * FRAC_W)) - RAD_W'(csqG1_q);
    tagG2_q.outcome <= outG1_q;
    tagG2_q.c       <= c_s;
    tagG2_q.omc     <= 32'((33'sd1 <<< FRAC_W) - c_s);
    tagG2_q.p00     <= Q_W'(rnd30(64'(p00G1_q)));
    tagG2_q.p01     <= Q_W'(rnd30(64'(p01G1_q)));
    tagG2_q.p11     <= Q_W'(rnd30(64'(p11G1_q)));
    tagG2_q.p01_neg <= n0negG1_q ^ n1negG1_q;
    tagG2_q.n0m     <= n0G1_q;
    tagG2_q.n1m     <= n1G1_q;
    tagG2_q.n0_neg  <= n0negG1_q;
    tagG2_q.n1_neg  <= n1negG1_q;
  end

  // sine = sqrt(2^60 - c^2)
  logic vS;
  logic [ROOT_W-1:0] sS;
  stag_t tS;

  azrot_isqrt #(
    .RAD_W (RAD_W),
    .TAG_W ($bits(stag_t))
  ) u_sin_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vG2_q),
    .rad_i   (radG2_q),
    .tag_i   (tagG2_q),
    .valid_o (vS),
    .root_o  (sS),
    .tag_o   (tS)
  );

  // H1: second products
  logic vH1_q;
  stag_t tH1_q;
  logic [KM_W-1:0] k00H1_q, k01H1_q, k11H1_q;
  logic [PR_W-1:0] n0sH1_q, n1sH1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vH1_q <= 1'b0;
    end else begin
      vH1_q <= vS;
    end
  end

  always_ff @(posedge clk_i) begin
    tH1_q   <= tS;
    k00H1_q <= KM_W'(tS.p00) * KM_W'(tS.omc);
    k01H1_q <= KM_W'(tS.p01) * KM_W'(tS.omc);
    k11H1_q <= KM_W'(tS.p11) * KM_W'(tS.omc);
    n0sH1_q <= PR_W'(tS.n0m) * PR_W'(sS);
    n1sH1_q <= PR_W'(tS.n1m) * PR_W'(sS);
  end

  // H2: round and apply signs
  logic vH2_q;
  logic [1:0] outH2_q;
  logic signed [SV_W-1:0] cH2_q, k00H2_q, k01H2_q, k11H2_q, n0sH2_q, n1sH2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vH2_q <= 1'b0;
    end else begin
      vH2_q <= vH1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    outH2_q <= tH1_q.outcome;
    cH2_q   <= SV_W'(tH1_q.c);
    k00H2_q <= signed_of(rnd30(64'(k00H1_q)), 1'b0);
    k01H2_q <= signed_of(rnd30(64'(k01H1_q)), tH1_q.p01_neg);
    k11H2_q <= signed_of(rnd30(64'(k11H1_q)), 1'b0);
    n0sH2_q <= signed_of(rnd30(64'(n0sH1_q)), tH1_q.n0_neg);
    n1sH2_q <= signed_of(rnd30(64'(n1sH1_q)), tH1_q.n1_neg);
  end

  // H3: sums, saturation, identity select
  logic done_q;
  logic [1:0] outcome_q;
  logic [OUT_W-1:0] rot_q [9];
  logic [OUT_W-1:0] rot_d [9];
  logic signed [AD_W-1:0] cx;

  assign cx = AD_W'(cH2_q);

  always_comb begin
    if (outH2_q == OUTCOME_ROTATED) begin
      rot_d[0] = sat(AD_W'(k11H2_q) + cx);
      rot_d[1] = sat(-AD_W'(n0sH2_q));
      rot_d[2] = sat(AD_W'(k01H2_q));
      rot_d[3] = sat(AD_W'(n0sH2_q));
      rot_d[4] = sat(cx);
      rot_d[5] = sat(-AD_W'(n1sH2_q));
      rot_d[6] = sat(AD_W'(k01H2_q));
      rot_d[7] = sat(AD_W'(n1sH2_q));
      rot_d[8] = sat(AD_W'(k00H2_q) + cx);
    end else begin
      for (int i = 0; i < 9; i++) begin
        rot_d[i] = (i % 4 == 0) ? OUT_W'(ONE_Q30) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vH2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    outcome_q <= outH2_q;
    for (int i = 0; i < 9; i++) begin
      rot_q[i] <= rot_d[i];
    end
  end

  assign done_o    = done_q;
  assign outcome_o = outcome_q;
  assign rot_o     = rot_q;

endmodule

/* src/align_to_neg_z_rotation_matrix.sv */
// Top level of the rotation matrix block that carries (0,0,-1) onto a vector.
// Depends on azrot_pkg, azrot_front, azrot_isqrt, azrot_div and azrot_back.
//
// Usage:
//   Drive disp_x_i/disp_y_i/disp_z_i (signed Q16.16) and raise start; the item
//   is taken at every rising edge with start high and busy low. busy is
//   always low: the block is a fixed pipeline and takes one item per cycle.
//   Each item yields one result: rot_00_o..rot_22_o (Q1.30, saturated to
//   +/-2^30) and outcome_o, marked by done_o for exactly one cycle. There
//   is no backpressure; the receiver must take every result.
//   Each item passes through 6 front stages (register, magnitude,
//   leading-one, shift, square, sum), a 31-stage square root for the norms,
//   a 32-stage divider, 2 product stages, a 31-stage root for the sine, and
//   3 product/round/saturate stages.
//   The threshold register is written through cfg_valid_i/cfg_ready_o/
//   cfg_data_i; ready is always high. Write it only while no item is in
//   flight. Reset sets it to 1 and clears every valid bit in the pipeline,
//   so no result appears until new items enter.
module align_to_neg_z_rotation_matrix
  import azrot_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] disp_x_i,
  input  logic [COORD_WIDTH-1:0] disp_y_i,
  input  logic [COORD_WIDTH-1:0] disp_z_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [THR_W-1:0]       cfg_data_i,
  output logic                   done_o,
  output logic [OUT_W-1:0]       rot_00_o,
  output logic [OUT_W-1:0]       rot_01_o,
  output logic [OUT_W-1:0]       rot_02_o,
  output logic [OUT_W-1:0]       rot_10_o,
  output logic [OUT_W-1:0]       rot_11_o,
  output logic [OUT_W-1:0]       rot_12_o,
  output logic [OUT_W-1:0]       rot_20_o,
  output logic [OUT_W-1:0]       rot_21_o,
  output logic [OUT_W-1:0]       rot_22_o,
  output logic [1:0]             outcome_o
);

  localparam int LTAG_W = $bits(front_flags_t) + MAG_W;

  // threshold register
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // front end: normalize and square
  logic              f_valid;
  front_flags_t      f_flags;
  logic [MAG_W-1:0]  f_mx, f_my, f_mz;
  logic [SUM_W-1:0]  f_sxy, f_sall;

  azrot_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .disp_x_i  (disp_x_i),
    .disp_y_i  (disp_y_i),
    .disp_z_i  (disp_z_i),
    .valid_o   (f_valid),
    .flags_o   (f_flags),
    .mag_x_o   (f_mx),
    .mag_y_o   (f_my),
    .mag_z_o   (f_mz),
    .sum_xy_o  (f_sxy),
    .sum_all_o (f_sall)
  );

  // L = |v| carries flags and z; R = |(x,y)| carries x and y
  logic              l_valid, r_valid;
  logic [ROOT_W-1:0] l_root, r_root;
  logic [LTAG_W-1:0] l_tag;
  logic [2*MAG_W-1:0] r_tag;
  front_flags_t      l_flags;
  logic [MAG_W-1:0]  l_mz, r_mx, r_my;

  azrot_isqrt #(
    .RAD_W (SUM_W),
    .TAG_W (LTAG_W)
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .rad_i   (f_sall),
    .tag_i   ({f_flags, f_mz}),
    .valid_o (l_valid),
    .root_o  (l_root),
    .tag_o   (l_tag)
  );

  azrot_isqrt #(
    .RAD_W (SUM_W),
    .TAG_W (2 * MAG_W)
  ) u_rad_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .rad_i   (f_sxy),
    .tag_i   ({f_mx, f_my}),
    .valid_o (r_valid),
    .root_o  (r_root),
    .tag_o   (r_tag)
  );

  assign {l_flags, l_mz} = l_tag;
  assign {r_mx, r_my}    = r_tag;

  // four quotients in lockstep
  logic            d_valid;
  logic            dn_valid, dc_valid, d0_valid, d1_valid;
  logic [Q_W-1:0]  q_norm, q_c, q_n0, q_n1;
  logic [1:0]      dn_tag;
  logic [2:0]      dn_negs;
  logic            dc_tag, d0_tag, d1_tag;

  assign d_valid = l_valid && r_valid;

  azrot_div #(.TAG_W (2)) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .num_i   (r_root),
    .den_i   (l_root),
    .tag_i   ({l_flags.zero, r_root == '0}),
    .valid_o (dn_valid),
    .quot_o  (q_norm),
    .tag_o   (dn_tag)
  );

  azrot_div #(.TAG_W (1)) u_div_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .num_i   (Q_W'(l_mz)),
    .den_i   (l_root),
    .tag_i   (l_flags.neg[2]),
    .valid_o (dc_valid),
    .quot_o  (q_c),
    .tag_o   (dc_tag)
  );

  azrot_div #(.TAG_W (1)) u_div_n0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .num_i   (Q_W'(r_my)),
    .den_i   (r_root),
    .tag_i   (l_flags.neg[1]),
    .valid_o (d0_valid),
    .quot_o  (q_n0),
    .tag_o   (d0_tag)
  );

  azrot_div #(.TAG_W (1)) u_div_n1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .num_i   (Q_W'(r_mx)),
    .den_i   (r_root),
    .tag_i   (l_flags.neg[0]),
    .valid_o (d1_valid),
    .quot_o  (q_n1),
    .tag_o   (d1_tag)
  );

  assign dn_negs = {dc_tag, d0_tag, d1_tag};

  // back end: sine, products, output register
  logic [OUT_W-1:0] rot [9];

  azrot_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dn_valid && dc_valid && d0_valid && d1_valid),
    .thr_i     (thr_q),
    .q_norm_i  (q_norm),
    .q_c_i     (q_c),
    .q_n0_i    (q_n0),
    .q_n1_i    (q_n1),
    .zero_i    (dn_tag[1]),
    .r_zero_i  (dn_tag[0]),
    .neg_i     (dn_negs),
    .done_o    (done_o),
    .rot_o     (rot),
    .outcome_o (outcome_o)
  );

  assign rot_00_o = rot[0];
  assign rot_01_o = rot[1];
  assign rot_02_o = rot[2];
  assign rot_10_o = rot[3];
  assign rot_11_o = rot[4];
  assign rot_12_o = rot[5];
  assign rot_20_o = rot[6];
  assign rot_21_o = rot[7];
  assign rot_22_o = rot[8];

endmodule

/* test/tb.sv */
// Testbench for align_to_neg_z_rotation_matrix: sends displacement vectors,
// predicts each rotation matrix in fixed point and checks every result.
// Depends on azrot_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
  import azrot_pkg::*;

  typedef struct packed {
    logic [8:0][OUT_W-1:0] rot;  // entry order rot_00 .. rot_22
    logic [1:0]            outcome;
  } matrix_t;

  localparam longint ONE_Q30 = 64'sd1 << 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] disp_x_i = '0, disp_y_i = '0, disp_z_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;
  logic        done_o;
  logic [OUT_W-1:0] rot_00_o, rot_01_o, rot_02_o, rot_10_o, rot_11_o, rot_12_o;
  logic [OUT_W-1:0] rot_20_o, rot_21_o, rot_22_o;
  logic [1:0]  outcome_o;

  // Predictor copy of the threshold register and the store of pending matrices
  logic [THR_W-1:0] thr_model = 16'd1;
  matrix_t          pending_mats[$];
  int               err_cnt = 0;
  int               burst_left = 0;

  align_to_neg_z_rotation_matrix #(.COORD_WIDTH(32)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .disp_x_i, .disp_y_i, .disp_z_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o,
    .rot_00_o, .rot_01_o, .rot_02_o, .rot_10_o, .rot_11_o, .rot_12_o,
    .rot_20_o, .rot_21_o, .rot_22_o, .outcome_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Integer square root, floor, bit-by-bit.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // num * 2^30 / den, rounded half away from zero, sign applied last.
  function automatic longint quot_q30(longint unsigned num, longint unsigned den, bit neg);
    longint unsigned r;
    r = ((num << 30) + den / 2) / den;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Q1.30 product, rounded half away from zero.
  function automatic longint prod_q30(longint a, longint b);
    longint unsigned ua, ub, r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = (ua * ub + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp_q30(longint v);
    if (v > ONE_Q30) v = ONE_Q30;
    if (v < -ONE_Q30) v = -ONE_Q30;
    return v[31:0];
  endfunction

  function automatic matrix_t identity_mat(logic [1:0] code);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.rot[i] = (i % 4 == 0) ? 32'h4000_0000 : '0;
    m.outcome = code;
    return m;
  endfunction

  function automatic matrix_t rodrigues_mat(logic [31:0] vx, logic [31:0] vy,
                                            logic [31:0] vz, logic [15:0] thr);
    logic [31:0]     v[3];
    longint unsigned mag[3], top, lnorm, rnorm, nnorm;
    bit              ng[3];
    longint          c, s, omc, n[3], k[3][3];
    matrix_t         m;
    v[0] = vx; v[1] = vy; v[2] = vz;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = v[i][31];
      mag[i] = ng[i] ? (64'h1_0000_0000 - v[i]) : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return identity_mat(OUTCOME_ZERO);
    // Bring the largest magnitude into [2^29, 2^30) with one common shift
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    lnorm = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    rnorm = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1]);
    nnorm = quot_q30(rnorm, lnorm, 1'b0);
    if (nnorm < thr || rnorm == 0) return identity_mat(OUTCOME_ALIGNED);
    c = quot_q30(mag[2], lnorm, !ng[2]);
    s = int_sqrt((64'd1 << 60) - c * c);
    omc = ONE_Q30 - c;
    n[0] = quot_q30(mag[1], rnorm, ng[1]);
    n[1] = quot_q30(mag[0], rnorm, !ng[0]);
    n[2] = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        k[a][b] = prod_q30(prod_q30(n[a], n[b]), omc);
    m.rot[0] = clamp_q30(k[1][1] + c);
    m.rot[1] = clamp_q30(k[2][1] - prod_q30(n[0], s));
    m.rot[2] = clamp_q30(k[0][1] + prod_q30(n[2], s));
    m.rot[3] = clamp_q30(k[1][2] + prod_q30(n[0], s));
    m.rot[4] = clamp_q30(k[2][2] + c);
    m.rot[5] = clamp_q30(k[0][2] - prod_q30(n[1], s));
    m.rot[6] = clamp_q30(k[1][0] - prod_q30(n[2], s));
    m.rot[7] = clamp_q30(k[2][0] + prod_q30(n[1], s));
    m.rot[8] = clamp_q30(k[0][0] + c);
    m.outcome = OUTCOME_ROTATED;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: done_o marks one matrix per cycle, no backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && done_o) begin
      got.rot = {rot_22_o, rot_21_o, rot_20_o, rot_12_o, rot_11_o, rot_10_o,
                 rot_02_o, rot_01_o, rot_00_o};
      got.outcome = outcome_o;
      if (pending_mats.size() == 0) begin
        $error("result with no item pending");
        err_cnt++;
      end else begin
        want = pending_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.rot[i] !== want.rot[i]) begin
            $error("rot_%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                   $signed(want.rot[i]), $signed(got.rot[i]));
            err_cnt++;
          end
        if (got.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item driver and helpers
  // ---------------------------------------------------------------------------

  // Drop start for a number of cycles.
  task automatic hold_idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Send one item; bursts of random length with random gaps between them.
  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) hold_idle($urandom_range(1, 12));
    end
    burst_left--;
    start <= 1'b1;
    disp_x_i <= x;
    disp_y_i <= y;
    disp_z_i <= z;
    do @(posedge clk_i); while (!(start && !busy));
    pending_mats.push_back(rodrigues_mat(x, y, z, thr_model));
  endtask

  // Hold off until every pending matrix has come out.
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    while (pending_mats.size() != 0) @(posedge clk_i);
  endtask

  // Write the threshold with the pipeline empty.
  task automatic write_threshold(logic [15:0] thr);
    drain_results();
    repeat (110) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_model = thr;
  endtask

  // Coordinate of random size: full range, shifted down, or a corner value.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1, 2: return $signed($urandom) >>> $urandom_range(0, 31);
      3: return $urandom_range(0, 3) - 1;
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners of the fields, zero vector and both poles at the reset threshold.
  task automatic test_corners();
    send_vec(0, 0, 0);
    send_vec(0, 0, 32'h0001_0000);
    send_vec(0, 0, 32'hffff_0000);
    send_vec(32'h0001_0000, 0, 0);
    send_vec(0, 32'hffff_0000, 0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(32'h8000_0000, 32'h7fff_ffff, 0);
    send_vec(1, 0, 0);
    send_vec(32'hffff_ffff, 1, 32'hffff_ffff);
    send_vec(1, 1, 32'h7fff_ffff);
    send_vec(0, 1, 32'h8000_0000);
    send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    send_vec(32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0);
    send_vec(3, 4, 0);
    send_vec(32'h0003_0000, 32'hfffc_0000, 32'h000c_0000);
  endtask

  // Thresholds at both extremes and near-pole vectors around them.
  task automatic test_thresholds();
    write_threshold(16'd0);
    send_vec(0, 0, 32'h1234_5678);
    send_vec(0, 0, 32'hedcb_a988);
    send_vec(1, 0, 32'h7fff_ffff);
    send_vec(0, 0, 0);
    write_threshold(16'hffff);
    send_vec(32'h0001_0000, 0, 32'h7fff_ffff);
    send_vec(32'h0004_0000, 32'h0004_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 0, 0);
    write_threshold(16'd1);
  endtask

  // Random vectors in phases of different thresholds.
  task automatic test_random(int count);
    logic [31:0] z;
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 200) write_threshold($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'd1);
      if (i % 500 == 250) drain_results();
      if ($urandom_range(0, 3) == 0) begin
        // near a pole: small x,y against a big z to probe the threshold
        z = $urandom;
        z[31:28] = $urandom_range(0, 1) ? 4'h7 : 4'h8;
        send_vec($signed($urandom) >>> $urandom_range(12, 31),
                 $signed($urandom) >>> $urandom_range(12, 31), z);
      end else begin
        send_vec(rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_thresholds();
    test_random(1600);
    drain_results();
    repeat (120) @(posedge clk_i);
    if (pending_mats.size() != 0) begin
      $error("%0d results never arrived", pending_mats.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** align_to_neg_z_rotation_matrix: PASSED **");
    end else begin
      $display("** align_to_neg_z_rotation_matrix: FAILED **");
    end
    $finish;
  end

  // Watchdog far above the slowest correct run
  initial begin
    #4000000;
    $display("** align_to_neg_z_rotation_matrix: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
src/azrot_pkg.sv
src/azrot_isqrt.sv
src/azrot_div.sv
src/azrot_front.sv
src/azrot_back.sv
src/align_to_neg_z_rotation_matrix.sv
test/tb.sv
